>>> rtl/omm_pkg.sv
// ----------------------------------------------------------------------------
// omm_pkg
// Shared types, widths and helpers of the one-mismatch string matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package omm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 7;
    localparam int SYM_W       = 8;
    localparam int PIDX_W      = 6;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = 2;
    localparam int POS_W       = 32;

    localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    // Control handed to every cell of the chain
    typedef struct packed {
        logic text;
        logic restart;
    } cell_ctl_t;

    // Item handed from the input decode to the result stage
    typedef struct packed {
        logic text;
        logic restart;
    } pend_t;

    function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] count,
                                                 input logic diff);
        logic [CNT_W:0] sum;
        sum = {1'b0, count} + {{CNT_W{1'b0}}, diff};
        return (sum > {1'b0, CNT_SAT}) ? CNT_SAT : sum[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/omm_cell.sv
// ----------------------------------------------------------------------------
// omm_cell
// One alignment cell: a pattern byte and a saturating mismatch count that
// takes its neighbour's count and adds its own comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module omm_cell
    import omm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic             load_en,
    input  logic [SYM_W-1:0] symbol,
    input  logic [CNT_W-1:0] prev_count,
    output logic [CNT_W-1:0] count
);

    logic [SYM_W-1:0] pattern_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_ff @(posedge aclk) begin
        if (load_en) begin
            pattern_reg <= symbol;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.restart) begin
            count_next = '0;
        end else if (ctl.text) begin
            count_next = add_sat(prev_count, symbol != pattern_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

>>> rtl/omm_result.sv
// ----------------------------------------------------------------------------
// omm_result
// Result stage: judges the top cell of the window, keeps the match total
// and holds the result item in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module omm_result
    import omm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  pend_t            pend_in,
    output logic             adv,
    input  logic [CNT_W-1:0] top_count,
    input  logic [LEN_W-1:0] len,
    input  logic [POS_W-1:0] text_seen,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] start_position,
    output logic [POS_W-1:0] match_total
);

    pend_t            pend_reg;
    logic             m_valid_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] total_reg;
    logic [POS_W-1:0] matches_reg;
    logic [POS_W-1:0] matches_inc;
    logic             hit;

    assign adv = !m_valid_reg || m_ready;

    assign hit = pend_reg.text && (text_seen >= POS_W'(len)) && (top_count <= 2'd1);

    assign matches_inc = (matches_reg == POS_MAX) ? matches_reg : matches_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
            matches_reg <= '0;
        end else if (adv) begin
            pend_reg    <= pend_in;
            m_valid_reg <= hit;
            if (pend_reg.restart) begin
                matches_reg <= '0;
            end else if (hit) begin
                matches_reg <= matches_inc;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (adv && hit) begin
            start_reg <= text_seen - POS_W'(len) + 1'b1;
            total_reg <= matches_inc;
        end
    end

    assign m_valid        = m_valid_reg;
    assign start_position = start_reg;
    assign match_total    = total_reg;

endmodule

>>> rtl/one_mismatch_string_matcher_core.sv
// ----------------------------------------------------------------------------
// one_mismatch_string_matcher_core
// A text item's result is registered first in the cell chain (counts and
//   pending flags), then in the output register of the result stage.
// Throughput: one item per cycle; every cell updates in parallel, and the
//   input stalls only while the output register holds an untaken result.
// Reset (aresetn low, synchronous): clears counts, text position, match count and the
//   pending/valid flags and sets pattern_length to 1; pattern bytes keep no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_mismatch_string_matcher_core
    import omm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration: pattern_length
    input  logic                 cfg_wr_en,
    input  logic [LEN_W-1:0]     cfg_wr_data,

    // Input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [7:0] symbol, [13:8] pattern_index, zero fill
    input  logic [KIND_W-1:0]    s_axis_tuser,   // [1:0] kind

    // Result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*POS_W-1:0]   m_axis_tdata    // [31:0] start_position, [63:32] match_total
);

    logic [LEN_W-1:0]  pattern_length_reg;
    logic [LEN_W-1:0]  len_eff;
    logic [IDX_W-1:0]  len_m1;

    logic [SYM_W-1:0]  symbol;
    logic [PIDX_W-1:0] pattern_index;
    logic              accept;
    logic              adv;

    logic              is_load;
    logic              is_text;
    logic              is_restart;

    cell_ctl_t         cell_ctl;
    pend_t             pend_in;

    logic [POS_W-1:0]  text_seen_reg;
    logic [POS_W-1:0]  text_seen_next;

    logic [CNT_W-1:0]  cnt [MAX_PATTERN];
    logic [CNT_W-1:0]  top_count;

    logic [POS_W-1:0]  start_position;
    logic [POS_W-1:0]  match_total;

    assign symbol        = s_axis_tdata[SYM_W-1:0];
    assign pattern_index = s_axis_tdata[SYM_W +: PIDX_W];

    // Accept whenever the result stage can advance
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Decode the item kind; the unused code does nothing
    always_comb begin
        is_load    = 1'b0;
        is_text    = 1'b0;
        is_restart = 1'b0;
        unique case (s_axis_tuser)
            KIND_LOAD:    is_load    = accept;
            KIND_TEXT:    is_text    = accept;
            KIND_RESTART: is_restart = accept;
            default: ;
        endcase
    end

    assign cell_ctl.text    = is_text;
    assign cell_ctl.restart = is_restart;
    assign pend_in.text     = is_text;
    assign pend_in.restart  = is_restart;

    // Configuration register: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(1);
        end else if (cfg_wr_en) begin
            pattern_length_reg <= cfg_wr_data;
        end
    end

    // Clamp the length into 1..MAX_PATTERN
    always_comb begin
        if (pattern_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = pattern_length_reg;
        end
    end
    assign len_m1 = IDX_W'(len_eff - 1'b1);

    // Text position counter: saturate, clear on restart
    always_comb begin
        text_seen_next = text_seen_reg;
        if (is_restart) begin
            text_seen_next = '0;
        end else if (is_text && text_seen_reg != POS_MAX) begin
            text_seen_next = text_seen_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_seen_reg <= '0;
        end else begin
            text_seen_reg <= text_seen_next;
        end
    end

    // Chain of cells: cell j takes cell j-1's count, cell 0 starts from zero
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [CNT_W-1:0] prev_count;
        logic             load_en;

        if (j == 0) begin : g_first
            assign prev_count = '0;
        end else begin : g_rest
            assign prev_count = cnt[j-1];
        end

        assign load_en = is_load && (32'(pattern_index) == 32'(j));

        omm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (cell_ctl),
            .load_en    (load_en),
            .symbol     (symbol),
            .prev_count (prev_count),
            .count      (cnt[j])
        );
    end

    // Window end: the cell of the last pattern symbol in use
    assign top_count = cnt[len_m1];

    omm_result u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pend_in        (pend_in),
        .adv            (adv),
        .top_count      (top_count),
        .len            (len_eff),
        .text_seen      (text_seen_reg),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .start_position (start_position),
        .match_total    (match_total)
    );

    assign m_axis_tdata = {match_total, start_position};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        is_restart |=> text_seen_reg == '0)
        else $error("text position not cleared after restart");

    a_text_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_text && text_seen_reg != POS_MAX) |=> text_seen_reg == $past(text_seen_reg) + 1'b1)
        else $error("text position did not advance");

    a_result_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (start_position != '0 && match_total != '0))
        else $error("result with zero position or total");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

endmodule
